/* rtl/lph_pkg.sv */
// ---------------------------------------------------------------------------
// lph_pkg: shared types and codes of the linear probe hash table
// Field widths, operation and status codes, and the item structs that
// travel between the front end, the queue and the probe engine.
// ---------------------------------------------------------------------------
package lph_pkg;

  // field widths
  localparam int OP_W  = 2;
  localparam int KEY_W = 16;
  localparam int PAY_W = 16;
  localparam int ST_W  = 2;
  localparam int IDX_W = 4;

  // home slot reduction: key bits consumed per cycle
  localparam int DIGIT_W   = 4;
  localparam int MOD_STEPS = KEY_W / DIGIT_W;
  localparam int STEP_W    = $clog2(MOD_STEPS);

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_DONE = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  // request item as taken in
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } req_t;

  // one table entry
  typedef struct packed {
    logic             valid;
    logic             mark;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } slot_t;

  // result item
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [PAY_W-1:0] payload;
    logic [IDX_W-1:0] index;
  } rsp_t;

endpackage

/* rtl/lph_if.sv */
// ---------------------------------------------------------------------------
// lph_if: request and response channels
// Valid/ready channels carrying the request and the result item fields.
// ---------------------------------------------------------------------------
interface lph_req_if;
  import lph_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [KEY_W-1:0] lookup_key;
  logic [PAY_W-1:0] payload_in;

  modport source (output valid, op, lookup_key, payload_in, input ready);
  modport sink   (input valid, op, lookup_key, payload_in, output ready);
endinterface

interface lph_rsp_if;
  import lph_pkg::*;

  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [PAY_W-1:0] payload_out;
  logic [IDX_W-1:0] slot_index;

  modport source (output valid, status, payload_out, slot_index, input ready);
  modport sink   (input valid, status, payload_out, slot_index, output ready);
endinterface

/* rtl/linear_probe_hash_table_unit.sv */
// ---------------------------------------------------------------------------
// linear_probe_hash_table_unit: open addressing table with linear probing
// Insert, lookup and remove on a table of SLOTS entries, one result item
// for every request item.
// ---------------------------------------------------------------------------
//
//   channel   dir  fields                          taken when
//   req_i     in   op, lookup_key, payload_in      req_i.valid && req_i.ready
//   rsp_o     out  status, payload_out, slot_index rsp_o.valid && rsp_o.ready
//
// after reset a clearing pass writes every slot; items can
// enter the front end meanwhile, the probe engine starts once it is done.
// front end: accept, home slot reduction over the key digits, then the push.
// probe engine: reads n = 1..SLOTS slots of an item from the single read port,
// then offers its result; it takes the next item once that result is loaded.
// a stalled result holds the next finished probe, then queue and front fill.
//
module linear_probe_hash_table_unit #(
  parameter int SLOTS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lph_req_if.sink   req_i,
  lph_rsp_if.source rsp_o
);
  import lph_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int DW = AW + $bits(req_t);

  logic          push_valid, push_ready;
  req_t          push_req;
  logic [AW-1:0] push_home;
  logic          pop_valid, pop_ready;
  req_t          pop_req;
  logic [AW-1:0] pop_home;
  logic [DW-1:0] pop_data;

  // intake and home slot
  lph_front #(.SLOTS(SLOTS), .AW(AW)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_req_o   (push_req),
    .push_home_o  (push_home)
  );

  // decoupling queue
  lph_queue #(.DW(DW)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_home, push_req}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign pop_req  = pop_data[$bits(req_t)-1:0];
  assign pop_home = pop_data[DW-1:$bits(req_t)];

  // probe engine
  lph_back #(.SLOTS(SLOTS), .AW(AW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_req_i   (pop_req),
    .pop_home_i  (pop_home),
    .rsp         (rsp_o)
  );

endmodule

/* rtl/lph_front.sv */
// ---------------------------------------------------------------------------
// lph_front: request intake and home slot computation
// Takes one request item, reduces its key modulo SLOTS one digit per cycle
// and hands the item with its home slot to the queue.
// ---------------------------------------------------------------------------
module lph_front #(
  parameter int SLOTS = 16,
  parameter int AW    = $clog2(SLOTS)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  lph_req_if.sink        req,
  output logic           push_valid_o,
  input  logic           push_ready_i,
  output lph_pkg::req_t  push_req_o,
  output logic [AW-1:0]  push_home_o
);
  import lph_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CALC = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  localparam logic [AW:0]       MODULUS   = (AW+1)'(SLOTS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MOD_STEPS - 1);

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  req_t              req_q, req_d;
  logic [KEY_W-1:0]  sh_q, sh_d;
  logic [AW-1:0]     rem_q, rem_d;
  logic [AW-1:0]     rem_next;

  // restoring remainder over one digit of the key
  always_comb begin
    logic [AW-1:0] r;
    logic [AW:0]   w;
    r = rem_q;
    for (int i = 0; i < DIGIT_W; i++) begin
      w = {r, sh_q[KEY_W-1-i]};
      if (w >= MODULUS) w = w - MODULUS;
      r = w[AW-1:0];
    end
    rem_next = r;
  end

  // intake sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    req_d   = req_q;
    sh_d    = sh_q;
    rem_d   = rem_q;
    case (state_q)
      F_IDLE: begin
        if (req.valid) begin
          req_d   = '{op: req.op, key: req.lookup_key, payload: req.payload_in};
          sh_d    = req.lookup_key;
          rem_d   = '0;
          step_d  = '0;
          state_d = F_CALC;
        end
      end
      F_CALC: begin
        sh_d   = sh_q << DIGIT_W;
        rem_d  = rem_next;
        step_d = step_q + 1'b1;
        if (step_q == LAST_STEP) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (push_ready_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign req.ready    = (state_q == F_IDLE);
  assign push_valid_o = (state_q == F_PUSH);
  assign push_req_o   = req_q;
  assign push_home_o  = rem_q;

endmodule

/* rtl/lph_queue.sv */
// ---------------------------------------------------------------------------
// lph_queue: two-entry decoupling queue
// Register queue between the front end and the probe engine.
// ---------------------------------------------------------------------------
module lph_queue #(
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  logic [DW-1:0] push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output logic [DW-1:0] pop_data_o
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [DW-1:0] buf_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_data_o   = buf_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) buf_q[wr_ptr_q] <= push_data_i;
  end

endmodule

/* rtl/lph_back.sv */
// ---------------------------------------------------------------------------
// lph_back: probe engine and slot memory
// Clears the slot memory after reset, then walks the slots of each item from its home
// slot, one memory read per cycle; a free-slot insert or remove hit writes back.
// ---------------------------------------------------------------------------
module lph_back #(
  parameter int SLOTS = 16,
  parameter int AW    = $clog2(SLOTS)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  lph_pkg::req_t  pop_req_i,
  input  logic [AW-1:0]  pop_home_i,
  lph_rsp_if.source      rsp
);
  import lph_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] a);
    nxt = (a == LAST_SLOT) ? '0 : a + 1'b1;
  endfunction

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  req_t          cur_q, cur_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] cnt_q, cnt_d;
  rsp_t          res_q, res_d;
  logic          wr_en_q, wr_en_d;
  logic [AW-1:0] wr_addr_q, wr_addr_d;
  slot_t         wr_data_q, wr_data_d;
  logic          out_valid_q, out_valid_d;
  rsp_t          out_q;

  slot_t         mem_q [SLOTS];
  slot_t         rd_q;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  slot_t         mem_wd;

  logic             out_load;
  logic             key_hit, last, finish;
  logic             mark_keep;
  logic [AW+IDX_W-1:0] idx_wide;
  logic [IDX_W-1:0] slot_idx;

  // probe status of the entry now read
  assign key_hit   = rd_q.valid && (rd_q.key == cur_q.key);
  assign last      = (cnt_q == LAST_SLOT);
  assign mark_keep = (cnt_q == '0) ? rd_q.mark : 1'b1;
  assign idx_wide  = (AW+IDX_W)'(addr_q);
  assign slot_idx  = idx_wide[IDX_W-1:0];

  // read address: home slot on start, else the following slot
  assign rd_addr = (state_q == S_IDLE) ? pop_home_i : nxt(addr_q);

  assign pop_ready_o = (state_q == S_IDLE);
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

  // memory write port: clearing pass or entry write-back
  assign mem_we = (state_q == S_CLEAR) || (out_load && wr_en_q);
  assign mem_wa = (state_q == S_CLEAR) ? clr_q : wr_addr_q;
  assign mem_wd = (state_q == S_CLEAR) ? slot_t'('0) : wr_data_q;

  // probe sequencer
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cur_d     = cur_q;
    addr_d    = addr_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    wr_en_d   = wr_en_q;
    wr_addr_d = wr_addr_q;
    wr_data_d = wr_data_q;
    finish    = 1'b0;
    case (state_q)
      S_CLEAR: begin
        clr_d = nxt(clr_q);
        if (clr_q == LAST_SLOT) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (pop_valid_i) begin
          cur_d   = pop_req_i;
          addr_d  = pop_home_i;
          cnt_d   = '0;
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        addr_d    = nxt(addr_q);
        cnt_d     = cnt_q + 1'b1;
        wr_addr_d = addr_q;
        case (cur_q.op)
          OP_INSERT: begin
            if (!rd_q.valid) begin
              finish    = 1'b1;
              res_d     = '{status: ST_DONE, payload: '0, index: slot_idx};
              wr_en_d   = 1'b1;
              wr_data_d = '{valid: 1'b1, mark: mark_keep, key: cur_q.key,
                            payload: cur_q.payload};
            end else if (last) begin
              finish  = 1'b1;
              res_d   = '{status: ST_FULL, payload: '0, index: '0};
              wr_en_d = 1'b0;
            end
          end
          OP_LOOKUP, OP_REMOVE: begin
            if ((cnt_q == '0) && !rd_q.valid && !rd_q.mark) begin
              // empty unmarked home slot: miss at once
              finish  = 1'b1;
              res_d   = '{status: ST_MISS, payload: '0, index: '0};
              wr_en_d = 1'b0;
            end else if (key_hit) begin
              finish    = 1'b1;
              res_d     = '{status: ST_DONE, payload: rd_q.payload, index: slot_idx};
              wr_en_d   = (cur_q.op == OP_REMOVE);
              wr_data_d = '{valid: 1'b0, mark: rd_q.mark, key: rd_q.key,
                            payload: rd_q.payload};
            end else if (last) begin
              finish  = 1'b1;
              res_d   = '{status: ST_MISS, payload: '0, index: '0};
              wr_en_d = 1'b0;
            end
          end
          default: begin
            finish  = 1'b1;
            res_d   = '{status: ST_MISS, payload: '0, index: '0};
            wr_en_d = 1'b0;
          end
        endcase
        if (finish) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load)       out_valid_d = 1'b1;
    else if (rsp.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      wr_en_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      wr_en_q     <= wr_en_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    addr_q    <= addr_d;
    cnt_q     <= cnt_d;
    res_q     <= res_d;
    wr_addr_q <= wr_addr_d;
    wr_data_q <= wr_data_d;
    if (out_load) out_q <= res_q;
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_q <= mem_q[rd_addr];
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.status      = out_q.status;
  assign rsp.payload_out = out_q.payload;
  assign rsp.slot_index  = out_q.index;

endmodule

/* rtl/lph_checker.sv */
// ---------------------------------------------------------------------------
// lph_checker: port level checks of the hash table unit
// Watches the request and response channels and flags slips over time.
// ---------------------------------------------------------------------------
module lph_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    req_valid_i,
  input logic                    req_ready_i,
  input logic                    rsp_valid_i,
  input logic                    rsp_ready_i,
  input logic [lph_pkg::ST_W-1:0]  rsp_status_i,
  input logic [lph_pkg::PAY_W-1:0] rsp_payload_i,
  input logic [lph_pkg::IDX_W-1:0] rsp_index_i
);
  import lph_pkg::*;

  logic       req_take, rsp_take;
  logic [2:0] open_q;

  assign req_take = req_valid_i && req_ready_i;
  assign rsp_take = rsp_valid_i && rsp_ready_i;

  // items taken in but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (req_take && !rsp_take) begin
      open_q <= open_q + 1'b1;
    end else if (rsp_take && !req_take) begin
      open_q <= open_q - 1'b1;
    end
  end

  // a stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its fields
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable(rsp_status_i) && $stable(rsp_payload_i) && $stable(rsp_index_i))
    else $error("result changed while stalled");

  // miss and full carry no handle and no slot
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != ST_DONE) |->
      (rsp_payload_i == '0) && (rsp_index_i == '0))
    else $error("failed item reports a handle or slot");

  // every result answers an earlier request
  a_rsp_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (open_q != '0))
    else $error("result without an open request");

endmodule

bind linear_probe_hash_table_unit lph_checker u_lph_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_status_i  (rsp_o.status),
  .rsp_payload_i (rsp_o.payload_out),
  .rsp_index_i   (rsp_o.slot_index)
);
